// File: hdl/sacl_pkg.sv
// Shared widths, register indexes and defaults for the cache LRU lookup unit.
package sacl_pkg;

    localparam int ADDR_W       = 64;
    localparam int CNT_W        = 32;
    localparam int SET_BITS_W   = 3;
    localparam int BLOCK_BITS_W = 4;
    localparam int WAYS_W       = 4;
    localparam int SHAMT_W      = 5;

    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

    localparam int DEF_MAX_SETS = 64;
    localparam int DEF_MAX_WAYS = 8;

    typedef logic [CNT_W-1:0] t_count;

    // Saturating increment of a running count
    function automatic t_count sat_inc(input t_count v);
        return (v == '1) ? v : v + t_count'(1);
    endfunction

endpackage

// File: hdl/sacl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/set_assoc_cache_lru_lookup_unit.sv
// Top level: set-associative cache lookup with exact LRU replacement and hit, miss and eviction counts.
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  ---------------------------------------
//  cfg       in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//  in        in         i_in_valid  / o_in_ready   i_address
//  out       out        o_out_valid / i_out_ready  o_hit, o_miss, o_evicted, o_*_total
//
// Each request first reads the set's row from the line memory at the accept edge; the
// lookup then compares the ways in use, writes the updated row back and loads the result
// register. A new request is taken only after that write-back, back in the idle state,
// as the single row memory is read, modified and written for each request in turn.
// After reset a clearing pass writes MAX_SETS rows before requests are taken. A result
// waiting on i_out_ready stalls the lookup only when a second result is ready to be
// loaded. Configuration writes are taken at any time.
module set_assoc_cache_lru_lookup_unit #(
    parameter int MAX_SETS = sacl_pkg::DEF_MAX_SETS,
    parameter int MAX_WAYS = sacl_pkg::DEF_MAX_WAYS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0] i_cfg_data,

    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [sacl_pkg::ADDR_W-1:0]     i_address,

    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_hit,
    output logic                            o_miss,
    output logic                            o_evicted,
    output logic [sacl_pkg::CNT_W-1:0]      o_hit_total,
    output logic [sacl_pkg::CNT_W-1:0]      o_miss_total,
    output logic [sacl_pkg::CNT_W-1:0]      o_evict_total
);

    localparam int ADDR_W    = sacl_pkg::ADDR_W;
    localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WW        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RW        = WW;
    localparam int WCNT_W    = $clog2(MAX_WAYS + 1) + 1;
    localparam int S_LIM_RAW = $clog2(MAX_SETS + 1) - 1;
    localparam int S_LIM     = (S_LIM_RAW > 7) ? 7 : S_LIM_RAW;
    localparam int TAG_OFF   = MAX_WAYS;
    localparam int RANK_OFF  = MAX_WAYS * (1 + ADDR_W);
    localparam int ROW_W     = MAX_WAYS * (1 + ADDR_W + RW);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_LOOK  = 2'd2;

    // Configuration registers
    logic [sacl_pkg::SET_BITS_W-1:0]   r_set_bits;
    logic [sacl_pkg::BLOCK_BITS_W-1:0] r_block_bits;
    logic [sacl_pkg::WAYS_W-1:0]       r_ways;

    logic [1:0]         r_state;
    logic [SET_W-1:0]   r_clr;
    logic [SET_W-1:0]   r_set;
    logic [ADDR_W-1:0]  r_tag;

    logic               r_out_valid;
    logic               r_hit;
    logic               r_miss;
    logic               r_evicted;
    sacl_pkg::t_count   r_hit_cnt;
    sacl_pkg::t_count   r_miss_cnt;
    sacl_pkg::t_count   r_evict_cnt;

    logic               in_acc;
    logic               look_go;
    logic [sacl_pkg::SET_BITS_W-1:0] eff_s;
    logic [sacl_pkg::SHAMT_W-1:0]    shamt;
    logic [SET_W-1:0]   set_mask;
    logic [SET_W-1:0]   in_set;
    logic [ADDR_W-1:0]  in_tag;
    logic [ADDR_W-1:0]  addr_sh;
    logic [WCNT_W-1:0]  eff_ways;

    logic               ram_we;
    logic [SET_W-1:0]   ram_waddr;
    logic [ROW_W-1:0]   ram_wdata;
    logic [ROW_W-1:0]   ram_rdata;
    logic [ROW_W-1:0]   new_row;

    logic               rd_valid [MAX_WAYS];
    logic [ADDR_W-1:0]  rd_tag   [MAX_WAYS];
    logic [RW-1:0]      rd_rank  [MAX_WAYS];

    logic               found;
    logic [WW-1:0]      hit_way;
    logic               empty_found;
    logic [WW-1:0]      empty_way;
    logic [WW-1:0]      victim;
    logic [RW-1:0]      best_rank;
    logic [WW-1:0]      touch_way;
    logic [RW-1:0]      touch_rank;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign look_go     = (r_state == S_LOOK) && (!r_out_valid || i_out_ready);

    // Effective geometry from the configuration
    always_comb begin
        eff_s = (r_set_bits > 3'(S_LIM)) ? 3'(S_LIM) : r_set_bits;
        shamt = sacl_pkg::SHAMT_W'(r_block_bits) + sacl_pkg::SHAMT_W'(eff_s);
        if (r_ways == '0) begin
            eff_ways = WCNT_W'(1);
        end else if (WCNT_W'(r_ways) > WCNT_W'(MAX_WAYS)) begin
            eff_ways = WCNT_W'(MAX_WAYS);
        end else begin
            eff_ways = WCNT_W'(r_ways);
        end
    end

    // Split the incoming address into set and tag
    assign set_mask = ~(~SET_W'(0) << eff_s);
    assign addr_sh  = i_address >> r_block_bits;
    assign in_set   = addr_sh[SET_W-1:0] & set_mask;
    assign in_tag   = i_address >> shamt;

    // Unpack the row read from memory
    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            rd_valid[w] = ram_rdata[w];
            rd_tag[w]   = ram_rdata[TAG_OFF + w*ADDR_W +: ADDR_W];
            rd_rank[w]  = ram_rdata[RANK_OFF + w*RW +: RW];
        end
    end

    // Search the ways in use: hit, first empty, least recently used
    always_comb begin
        found       = 1'b0;
        hit_way     = '0;
        empty_found = 1'b0;
        empty_way   = '0;
        victim      = '0;
        best_rank   = rd_rank[0];
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (WCNT_W'(w) < eff_ways) begin
                if (!found && rd_valid[w] && (rd_tag[w] == r_tag)) begin
                    found   = 1'b1;
                    hit_way = WW'(w);
                end
                if (!empty_found && !rd_valid[w]) begin
                    empty_found = 1'b1;
                    empty_way   = WW'(w);
                end
                if ((w > 0) && (rd_rank[w] > best_rank)) begin
                    best_rank = rd_rank[w];
                    victim    = WW'(w);
                end
            end
        end
        touch_way  = found ? hit_way : victim;
        touch_rank = rd_rank[touch_way];
    end

    // Build the updated row: age younger lines (all valid on a fill), make the chosen line most recent
    always_comb begin
        new_row = ram_rdata;
        for (int j = 0; j < MAX_WAYS; j++) begin
            if (found || !empty_found) begin
                if (WW'(j) == touch_way) begin
                    new_row[RANK_OFF + j*RW +: RW] = '0;
                    if (!found) begin
                        new_row[TAG_OFF + j*ADDR_W +: ADDR_W] = r_tag;
                    end
                end else if (rd_valid[j] && (rd_rank[j] < touch_rank)) begin
                    new_row[RANK_OFF + j*RW +: RW] = rd_rank[j] + RW'(1);
                end
            end else begin
                if (WW'(j) == empty_way) begin
                    new_row[j]                            = 1'b1;
                    new_row[TAG_OFF + j*ADDR_W +: ADDR_W] = r_tag;
                    new_row[RANK_OFF + j*RW +: RW]        = '0;
                end else if (rd_valid[j]) begin
                    new_row[RANK_OFF + j*RW +: RW] = rd_rank[j] + RW'(1);
                end
            end
        end
    end

    // Memory write port: clearing pass, then write-back of looked-up rows
    always_comb begin
        ram_we    = (r_state == S_CLEAR) || look_go;
        ram_waddr = (r_state == S_CLEAR) ? r_clr : r_set;
        ram_wdata = (r_state == S_CLEAR) ? '0 : new_row;
    end

    sacl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SETS),
        .AW    (SET_W)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_acc),
        .i_raddr (in_set),
        .o_rdata (ram_rdata)
    );

    // Take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= '0;
            r_block_bits <= '0;
            r_ways       <= sacl_pkg::WAYS_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sacl_pkg::CFG_SET_BITS:   r_set_bits   <= i_cfg_data[sacl_pkg::SET_BITS_W-1:0];
                sacl_pkg::CFG_BLOCK_BITS: r_block_bits <= i_cfg_data;
                sacl_pkg::CFG_WAYS:       r_ways       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequence clearing pass, accept and lookup
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + SET_W'(1);
                    if (r_clr == SET_W'(MAX_SETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (look_go) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Hold the request's set and tag
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_set <= in_set;
            r_tag <= in_tag;
        end
    end

    // Advance the counters and load the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_evict_cnt <= '0;
        end else if (look_go) begin
            r_out_valid <= 1'b1;
            if (found) begin
                r_hit_cnt <= sacl_pkg::sat_inc(r_hit_cnt);
            end else begin
                r_miss_cnt <= sacl_pkg::sat_inc(r_miss_cnt);
                if (!empty_found) begin
                    r_evict_cnt <= sacl_pkg::sat_inc(r_evict_cnt);
                end
            end
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result flags
    always_ff @(posedge i_clk) begin
        if (look_go) begin
            r_hit     <= found;
            r_miss    <= !found;
            r_evicted <= !found && !empty_found;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_hit;
    assign o_miss        = r_miss;
    assign o_evicted     = r_evicted;
    assign o_hit_total   = r_hit_cnt;
    assign o_miss_total  = r_miss_cnt;
    assign o_evict_total = r_evict_cnt;

endmodule

// File: tb/set_assoc_cache_lru_lookup_checker.sv
// Checker for the cache LRU lookup unit: predicts every lookup and compares each result.
module set_assoc_cache_lru_lookup_checker #(
    parameter int MAX_SETS = sacl_pkg::DEF_MAX_SETS,
    parameter int MAX_WAYS = sacl_pkg::DEF_MAX_WAYS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [sacl_pkg::ADDR_W-1:0]     i_address,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic                            i_hit,
    input  logic                            i_miss,
    input  logic                            i_evicted,
    input  logic [sacl_pkg::CNT_W-1:0]      i_hit_total,
    input  logic [sacl_pkg::CNT_W-1:0]      i_miss_total,
    input  logic [sacl_pkg::CNT_W-1:0]      i_evict_total,
    output int                              o_fail_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_W      = sacl_pkg::ADDR_W;
    localparam int LINES       = MAX_SETS * MAX_WAYS;
    localparam int RANK_W      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int SET_LIM_RAW = $clog2(MAX_SETS + 1) - 1;
    localparam int SET_LIM     = (SET_LIM_RAW > 7) ? 7 : SET_LIM_RAW;

    typedef struct packed {
        logic             hit;
        logic             miss;
        logic             evicted;
        sacl_pkg::t_count hit_total;
        sacl_pkg::t_count miss_total;
        sacl_pkg::t_count evict_total;
    } t_access_result;

    // Shadow cache state and register copies
    logic                              way_valid [LINES];
    logic [ADDR_W-1:0]                 way_tag   [LINES];
    logic [RANK_W-1:0]                 way_age   [LINES];
    sacl_pkg::t_count                  hit_count;
    sacl_pkg::t_count                  miss_count;
    sacl_pkg::t_count                  evict_count;
    logic [sacl_pkg::SET_BITS_W-1:0]   set_bits_q;
    logic [sacl_pkg::BLOCK_BITS_W-1:0] block_bits_q;
    logic [sacl_pkg::WAYS_W-1:0]       ways_q;

    t_access_result expected_results [$];
    int mismatches  = 0;
    int pending     = 0;
    int results_seen = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = pending;

    task automatic report_mismatch(input string what);
        if (mismatches < 50)
            $display("%0t ns: ERROR on result %0d: %s", $time, results_seen, what);
        mismatches++;
    endtask

    function automatic sacl_pkg::t_count bump(input sacl_pkg::t_count v);
        return v + sacl_pkg::t_count'(v != '1);
    endfunction

    // Move one way to the most recently used slot, aging the younger lines of its set
    function automatic void promote_way(input int unsigned base, input int unsigned w);
        logic [RANK_W-1:0] age;
        age = way_age[base + w];
        for (int j = 0; j < MAX_WAYS; j++)
            if (way_valid[base + j] && way_age[base + j] < age)
                way_age[base + j]++;
        way_age[base + w] = '0;
    endfunction

    // Look up one address, update the shadow cache and return the expected result
    function automatic t_access_result predict_access(input logic [ADDR_W-1:0] addr);
        t_access_result    res;
        int unsigned       sb;
        int unsigned       ways;
        int unsigned       base;
        int unsigned       victim;
        int                found;
        int                empty;
        logic [ADDR_W-1:0] tag;
        res = '0;
        sb = (set_bits_q > SET_LIM) ? SET_LIM : set_bits_q;
        ways = (ways_q == 0) ? 1 : ((ways_q > MAX_WAYS) ? MAX_WAYS : ways_q);
        base = int'((addr >> block_bits_q) & ((64'd1 << sb) - 64'd1)) * MAX_WAYS;
        tag = addr >> (block_bits_q + sb);
        found = -1;
        empty = -1;
        for (int w = 0; w < ways; w++) begin
            if (way_valid[base + w] && way_tag[base + w] == tag) begin
                found = w;
                break;
            end
        end
        if (found >= 0) begin
            res.hit = 1'b1;
            hit_count = bump(hit_count);
            promote_way(base, found);
        end else begin
            res.miss = 1'b1;
            miss_count = bump(miss_count);
            for (int w = 0; w < ways; w++) begin
                if (!way_valid[base + w]) begin
                    empty = w;
                    break;
                end
            end
            if (empty >= 0) begin
                // fill the free way as youngest, aging every valid line of the set
                for (int j = 0; j < MAX_WAYS; j++)
                    if (way_valid[base + j])
                        way_age[base + j]++;
                way_valid[base + empty] = 1'b1;
                way_tag[base + empty]   = tag;
                way_age[base + empty]   = '0;
            end else begin
                // replace the oldest searched way
                victim = 0;
                for (int w = 1; w < ways; w++)
                    if (way_age[base + w] > way_age[base + victim])
                        victim = w;
                res.evicted = 1'b1;
                evict_count = bump(evict_count);
                promote_way(base, victim);
                way_tag[base + victim] = tag;
            end
        end
        res.hit_total   = hit_count;
        res.miss_total  = miss_count;
        res.evict_total = evict_count;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_access_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < LINES; i++)
                way_valid[i] = 1'b0;
            hit_count    = '0;
            miss_count   = '0;
            evict_count  = '0;
            set_bits_q   = '0;
            block_bits_q = '0;
            ways_q       = sacl_pkg::WAYS_W'(1);
            expected_results.delete();
        end else begin
            // track register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    sacl_pkg::CFG_SET_BITS:
                        set_bits_q   = i_cfg_data[sacl_pkg::SET_BITS_W-1:0];
                    sacl_pkg::CFG_BLOCK_BITS:
                        block_bits_q = i_cfg_data[sacl_pkg::BLOCK_BITS_W-1:0];
                    sacl_pkg::CFG_WAYS:
                        ways_q       = i_cfg_data[sacl_pkg::WAYS_W-1:0];
                    default: ;
                endcase
            end
            // compare each result with the oldest expectation
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    want = expected_results.pop_front();
                    if (i_hit !== want.hit)
                        report_mismatch($sformatf("hit %b, want %b", i_hit, want.hit));
                    if (i_miss !== want.miss)
                        report_mismatch($sformatf("miss %b, want %b", i_miss, want.miss));
                    if (i_evicted !== want.evicted)
                        report_mismatch($sformatf("evicted %b, want %b",
                                                  i_evicted, want.evicted));
                    if (i_hit_total !== want.hit_total)
                        report_mismatch($sformatf("hit_total %0d, want %0d",
                                                  i_hit_total, want.hit_total));
                    if (i_miss_total !== want.miss_total)
                        report_mismatch($sformatf("miss_total %0d, want %0d",
                                                  i_miss_total, want.miss_total));
                    if (i_evict_total !== want.evict_total)
                        report_mismatch($sformatf("evict_total %0d, want %0d",
                                                  i_evict_total, want.evict_total));
                end
                results_seen++;
            end
            // predict every accepted request
            if (i_in_valid && i_in_ready)
                expected_results.push_back(predict_access(i_address));
        end
        pending = expected_results.size();
    end

endmodule

// File: tb/set_assoc_cache_lru_lookup_unit_tb.sv
// Testbench top for the cache LRU lookup unit: drives accesses and registers, gives the verdict.
module set_assoc_cache_lru_lookup_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_W          = sacl_pkg::ADDR_W;
    localparam int CFG_IDX_W       = sacl_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W      = sacl_pkg::CFG_DATA_W;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 72;
    localparam int POOL_MAX        = 12;
    localparam int SET_LIM         = $clog2(sacl_pkg::DEF_MAX_SETS + 1) - 1;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [CFG_IDX_W-1:0]          i_cfg_index;
    logic [CFG_DATA_W-1:0]         i_cfg_data;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic [ADDR_W-1:0]             i_address;
    logic                          o_out_valid;
    logic                          i_out_ready;
    logic                          o_hit;
    logic                          o_miss;
    logic                          o_evicted;
    logic [sacl_pkg::CNT_W-1:0]    o_hit_total;
    logic [sacl_pkg::CNT_W-1:0]    o_miss_total;
    logic [sacl_pkg::CNT_W-1:0]    o_evict_total;

    int fail_count;
    int pending;
    bit calm = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    set_assoc_cache_lru_lookup_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_address     (i_address),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_hit         (o_hit),
        .o_miss        (o_miss),
        .o_evicted     (o_evicted),
        .o_hit_total   (o_hit_total),
        .o_miss_total  (o_miss_total),
        .o_evict_total (o_evict_total)
    );

    set_assoc_cache_lru_lookup_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_address     (i_address),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_hit         (o_hit),
        .i_miss        (o_miss),
        .i_evicted     (o_evicted),
        .i_hit_total   (o_hit_total),
        .i_miss_total  (o_miss_total),
        .i_evict_total (o_evict_total),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Stall the result side at random, except during the calm stretch
    always @(posedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(99) >= 8);
    end

    // Hold one register write until it is taken; valid stays up for the next write
    task automatic cfg_write(input logic [CFG_IDX_W-1:0]  idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Drop the request valid and wait until every result has come back
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic apply_config(input logic [CFG_DATA_W-1:0] set_bits,
                                input logic [CFG_DATA_W-1:0] block_bits,
                                input logic [CFG_DATA_W-1:0] ways);
        settle();
        cfg_write(sacl_pkg::CFG_SET_BITS, set_bits);
        cfg_write(sacl_pkg::CFG_BLOCK_BITS, block_bits);
        cfg_write(sacl_pkg::CFG_WAYS, ways);
        i_cfg_valid <= 1'b0;
    endtask

    // Send one access request, sometimes after a short gap
    task automatic send_access(input logic [ADDR_W-1:0] addr);
        if (!calm && $urandom_range(99) < 8) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_address  <= addr;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Random address whose set field is one of two chosen sets
    function automatic logic [ADDR_W-1:0] make_line(input int unsigned set_w,
                                                   input int unsigned blk_w,
                                                   input logic [ADDR_W-1:0] set_a,
                                                   input logic [ADDR_W-1:0] set_b);
        logic [ADDR_W-1:0] set_mask;
        logic [ADDR_W-1:0] pick;
        set_mask = ((64'd1 << set_w) - 64'd1) << blk_w;
        pick = ($urandom_range(1) != 0) ? set_a : set_b;
        return ({$urandom, $urandom} & ~set_mask) | ((pick << blk_w) & set_mask);
    endfunction

    initial begin
        logic [ADDR_W-1:0]     hot_lines [POOL_MAX];
        logic [ADDR_W-1:0]     addr;
        logic [ADDR_W-1:0]     off_mask;
        logic [ADDR_W-1:0]     set_a;
        logic [ADDR_W-1:0]     set_b;
        logic [CFG_DATA_W-1:0] sb;
        logic [CFG_DATA_W-1:0] bb;
        logic [CFG_DATA_W-1:0] wb;
        int unsigned           set_w;
        int unsigned           pool_n;
        int unsigned           k;
        int unsigned           pick;
        int                    item_no;

        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_address   <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: one set, one way, no offset; alternate extremes
        send_access('0);
        send_access('0);
        send_access('1);
        send_access('1);
        send_access(64'hAAAA_AAAA_AAAA_AAAA);
        send_access('0);

        // Set bits past the limit, block bits above twelve, ways of zero
        apply_config(4'd7, 4'd15, 4'd0);
        send_access('1);
        send_access('1);
        send_access(64'h8000_0000_0000_0000);
        send_access(64'h5555_5555_5555_5555);

        // Set bits with high data bits, ways too large: overfill one set
        apply_config(4'd14, 4'd12, 4'd15);
        for (int t = 0; t < 9; t++)
            send_access((64'(t) << 60) | (64'd5 << 12) | 64'hFFF);
        send_access((64'd1 << 60) | (64'd5 << 12));
        send_access((64'd0 << 60) | (64'd5 << 12) | 64'h123);

        // Random phases over a small working set, with noise and churn
        item_no = 0;
        for (int p = 0; p < PHASES; p++) begin
            sb = $urandom_range(15);
            bb = $urandom_range(15);
            wb = $urandom_range(15);
            apply_config(sb, bb, wb);
            set_w = (sb[2:0] > SET_LIM) ? SET_LIM : sb[2:0];
            off_mask = (64'd1 << bb) - 64'd1;
            set_a = $urandom;
            set_b = $urandom;
            pool_n = $urandom_range(2, POOL_MAX);
            for (int i = 0; i < pool_n; i++)
                hot_lines[i] = make_line(set_w, bb, set_a, set_b);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                calm = (item_no >= 150 && item_no < 250);
                pick = $urandom_range(99);
                k = $urandom_range(pool_n - 1);
                if (pick < 15) begin
                    addr = {$urandom, $urandom};
                end else if (pick < 22) begin
                    hot_lines[k] = make_line(set_w, bb, set_a, set_b);
                    addr = hot_lines[k];
                end else begin
                    addr = (hot_lines[k] & ~off_mask) | ({$urandom, $urandom} & off_mask);
                end
                send_access(addr);
                item_no++;
            end
        end
        calm = 1'b0;

        // Drain, let the pipeline go quiet, then give the verdict
        settle();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("set_assoc_cache_lru_lookup_unit_tb passed");
        else
            $display("set_assoc_cache_lru_lookup_unit_tb failed");
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #2ms;
        $display("set_assoc_cache_lru_lookup_unit_tb failed");
        $finish;
    end

endmodule

// File: sim.f
hdl/sacl_pkg.sv
hdl/sacl_ram.sv
hdl/set_assoc_cache_lru_lookup_unit.sv
tb/set_assoc_cache_lru_lookup_checker.sv
tb/set_assoc_cache_lru_lookup_unit_tb.sv
